@@ src/assert_macros.svh @@
// Concurrent assertion helpers, sampled on clk_i, off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/smpq_pkg.sv @@
package smpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [31:0] value_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef struct packed {
    logic   operation;
    value_t value;
  } in_t;

  typedef struct packed {
    value_t     top_value;
    logic       empty_res;
    logic [4:0] count;
    logic       overflow;
    logic       underflow;
  } out_t;

  typedef struct packed {
    logic push_en;
    logic pop_en;
    logic occupied;
    logic at_tail;
  } cell_ctrl_t;

endpackage

@@ src/sorted_min_priority_queue.sv @@
// A result reaches the output register in the cycle after its input transfer.
// Throughput: one push or pop per cycle while the input is not stalled; every cell
// compares and shifts in that cycle. The input stalls only while the output register
// is full and its consumer stalls. Reset clears the entry count and the output valid;
// stored entries are not cleared and are never observed before being written.
module sorted_min_priority_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  smpq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output smpq_pkg::out_t out_data_o
);
  import smpq_pkg::*;

  cnt_t   cnt_q;
  cnt_t   cnt_d;
  logic   out_valid_q;
  logic   out_valid_d;
  out_t   out_data_q;
  out_t   out_data_d;
  logic   in_xfer;
  logic   is_push;
  logic   full;
  logic   empty;
  logic   push_en;
  logic   pop_en;
  logic [CNT_W+4:0] cnt_ext;

  logic   gt         [CAPACITY];
  value_t entry      [CAPACITY];
  value_t entry_next [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign is_push    = (op_e'(in_data_i.operation) == OP_PUSH);
  assign full       = (cnt_q == CNT_W'(CAPACITY));
  assign empty      = (cnt_q == '0);
  assign push_en    = in_xfer && is_push && !full;
  assign pop_en     = in_xfer && !is_push && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic       prev_gt;
    value_t     prev_entry;
    value_t     next_entry;

    assign ctrl.push_en  = push_en;
    assign ctrl.pop_en   = pop_en;
    assign ctrl.occupied = (CNT_W'(i) < cnt_q);
    assign ctrl.at_tail  = (CNT_W'(i) == cnt_q);

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_gt    = gt[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .ins_value_i  (in_data_i.value),
      .prev_gt_i    (prev_gt),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .gt_o         (gt[i]),
      .entry_o      (entry[i]),
      .entry_next_o (entry_next[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign cnt_ext = {5'd0, cnt_d};

  always_comb begin
    out_data_d.top_value = (cnt_d == '0) ? '0 : entry_next[0];
    out_data_d.empty_res = (cnt_d == '0);
    out_data_d.count     = cnt_ext[4:0];
    out_data_d.overflow  = in_xfer && is_push && full;
    out_data_d.underflow = in_xfer && !is_push && empty;
  end

  assign out_valid_d = in_xfer || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ src/smpq_cell.sv @@
module smpq_cell (
  input  logic                clk_i,
  input  smpq_pkg::cell_ctrl_t ctrl_i,
  input  smpq_pkg::value_t    ins_value_i,
  input  logic                prev_gt_i,
  input  smpq_pkg::value_t    prev_entry_i,
  input  smpq_pkg::value_t    next_entry_i,
  output logic                gt_o,
  output smpq_pkg::value_t    entry_o,
  output smpq_pkg::value_t    entry_next_o
);
  import smpq_pkg::*;

  value_t entry_q;
  value_t entry_d;

  // Entry is occupied and strictly greater than the incoming value.
  assign gt_o = ctrl_i.occupied && (ins_value_i < entry_q);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push_en) begin
      if (prev_gt_i) begin
        entry_d = prev_entry_i;
      end else if (gt_o || ctrl_i.at_tail) begin
        entry_d = ins_value_i;
      end
    end else if (ctrl_i.pop_en) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign entry_next_o = entry_d;

endmodule

@@ src/smpq_chk.sv @@
`include "assert_macros.svh"

module smpq_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input smpq_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input smpq_pkg::out_t out_data_o
);
  import smpq_pkg::*;

  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")

  `ASSERT_NEXT(a_result_follows, in_valid_i && !in_stall_o, out_valid_o && ($past(in_data_i.operation) ? !out_data_o.overflow : !out_data_o.underflow), "missing or mismatched result")

  `ASSERT_IMPL(a_empty_top, out_valid_o && out_data_o.empty_res, (out_data_o.top_value == '0) && (out_data_o.count == '0), "empty result with nonzero top or count")

  `ASSERT_IMPL(a_flags_excl, out_valid_o, !(out_data_o.overflow && out_data_o.underflow), "overflow and underflow together")

endmodule

bind sorted_min_priority_queue smpq_chk u_smpq_chk (.*);

@@ tb/sorted_min_priority_queue_test.sv @@
module sorted_min_priority_queue_test;
  import smpq_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  class sorted_queue_tracker;
    value_t held[CAPACITY];
    int     held_count;
    out_t   awaited_results[$];
    int     errors;

    function new();
      held_count = 0;
      errors     = 0;
    endfunction

    function void note_transfer(in_t req);
      out_t exp;
      int   slot;
      int   i;
      exp = '0;
      if (req.operation == OP_PUSH) begin
        if (held_count >= CAPACITY) begin
          exp.overflow = 1'b1;
        end else begin
          slot = 0;
          while (slot < held_count && !($signed(req.value) < $signed(held[slot]))) slot++;
          for (i = held_count; i > slot; i--) held[i] = held[i-1];
          held[slot] = req.value;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          exp.underflow = 1'b1;
        end else begin
          for (i = 0; i + 1 < held_count; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      exp.top_value = (held_count == 0) ? '0 : held[0];
      exp.empty_res = (held_count == 0);
      exp.count     = 5'(held_count);
      awaited_results.push_back(exp);
    endfunction

    function void check_transfer(out_t got);
      out_t exp;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, got);
        errors++;
        return;
      end
      exp = awaited_results.pop_front();
      if (got.top_value !== exp.top_value) begin
        $display("%0t: top_value expected %0d actual %0d", $time, exp.top_value,
                 got.top_value);
        errors++;
      end
      if (got.empty_res !== exp.empty_res) begin
        $display("%0t: empty_res expected %0b actual %0b", $time, exp.empty_res,
                 got.empty_res);
        errors++;
      end
      if (got.count !== exp.count) begin
        $display("%0t: count expected %0d actual %0d", $time, exp.count, got.count);
        errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time, exp.overflow,
                 got.overflow);
        errors++;
      end
      if (got.underflow !== exp.underflow) begin
        $display("%0t: underflow expected %0b actual %0b", $time, exp.underflow,
                 got.underflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni     = 1'b0;
  logic in_valid   = 1'b0;
  in_t  in_data    = '0;
  logic out_stall  = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  logic steady_in    = 1'b0;
  logic steady_out   = 1'b0;
  logic hold_request = 1'b0;
  int   hold_left    = 0;
  int   cycles       = 0;

  sorted_queue_tracker tracker = new();

  sorted_min_priority_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: check on transfer, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) tracker.check_transfer(out_data_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_out && ($urandom_range(99) < 23);
      end
    end
  end

  function automatic value_t pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(6) - 3;
      7:          return 32'h7fff_ffff;
      8:          return 32'h8000_0000;
      default:    return $urandom_range(1) ? 32'h7fff_fff0 + $urandom_range(15)
                                          : 32'h8000_0000 + $urandom_range(15);
    endcase
  endfunction

  function automatic in_t pick_item(int push_pct);
    in_t item;
    item.operation = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
    item.value     = pick_value();
    return item;
  endfunction

  task automatic send_item(input in_t item);
    if (!steady_in) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_transfer(item);
  endtask

  task automatic send_op(input op_e op, input value_t value);
    in_t item;
    item.operation = op;
    item.value     = value;
    send_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int ph;
    int k;
    int len;
    int push_pct;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pop on empty, extremes, equal values, drain past empty
    send_op(OP_POP, 32'h1234_5678);
    send_op(OP_PUSH, 32'h7fff_ffff);
    send_op(OP_PUSH, 32'h8000_0000);
    send_op(OP_PUSH, 32'h0000_0000);
    send_op(OP_PUSH, 32'hffff_ffff);
    send_op(OP_PUSH, 32'hffff_ffff);
    send_op(OP_PUSH, 32'h0000_0000);
    send_op(OP_PUSH, 32'h8000_0000);
    repeat (8) send_op(OP_POP, 32'hffff_ffff);
    wait_drained();

    // phase 0 fills past capacity, phase 1 drains past empty
    for (ph = 0; ph < 15; ph++) begin
      case (ph)
        0:       push_pct = 100;
        1:       push_pct = 0;
        default: push_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 25 : 55;
      endcase
      len        = (ph < 2) ? 20 : $urandom_range(25, 50);
      steady_in  = (ph == 4);
      steady_out = (ph == 4);
      if (ph == 7) hold_request = 1'b1;
      for (k = 0; k < len; k++) send_item(pick_item(push_pct));
      if (ph % 3 == 2) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/smpq_pkg.sv
src/smpq_cell.sv
src/sorted_min_priority_queue.sv
src/smpq_chk.sv
tb/sorted_min_priority_queue_test.sv
